>>> src/prfa_pkg.sv
// ----------------------------------------------------------------------------
// prfa_pkg
// Shared constants, types and the command struct of the paired-resource arbiter.
// ----------------------------------------------------------------------------
package prfa_pkg;

  localparam int unsigned Clients    = 5;
  localparam int unsigned UsageWidth = 32;
  localparam int unsigned MaskWidth  = 5;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned IdWidth    = $clog2(Clients);
  localparam int unsigned CntWidth   = $clog2(Clients + 1);
  localparam logic [WeightWidth-1:0] WeightReset = WeightWidth'(100);

  typedef logic [IdWidth-1:0]    id_t;
  typedef logic [CntWidth-1:0]   cnt_t;
  typedef logic [UsageWidth-1:0] usage_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture masks, apply releases
    logic insert;    // sorted insert of client cur into both its queues
    logic grant;     // grant test for client cur
    logic publish;   // copy the finished tick into the result registers
    id_t  cur;
  } prfa_cmd_t;

  function automatic id_t right_of(id_t c);
    right_of = (c == id_t'(Clients - 1)) ? id_t'(0) : id_t'(c + id_t'(1));
  endfunction

endpackage

>>> src/prfa_ctrl.sv
// ----------------------------------------------------------------------------
// prfa_ctrl
// Sequencer: load, one insert step per client, one grant step per client, output step.
// ----------------------------------------------------------------------------
module prfa_ctrl import prfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output prfa_cmd_t cmd_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_INS, ST_GNT, ST_OUT} state_e;

  state_e state_q;
  id_t    cur_q;
  logic   valid_q;

  assign in_ready  = (state_q == ST_IDLE);
  assign out_valid = valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.cur     = cur_q;
    cmd_o.load    = in_valid && in_ready;
    cmd_o.insert  = (state_q == ST_INS);
    cmd_o.grant   = (state_q == ST_GNT);
    cmd_o.publish = (state_q == ST_OUT) && (!valid_q || out_ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (valid_q && out_ready && state_q != ST_OUT) valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid) begin
            state_q <= ST_INS;
            cur_q   <= '0;
          end
        end
        ST_INS: begin
          if (cur_q == id_t'(Clients - 1)) begin
            cur_q   <= '0;
            state_q <= ST_GNT;
          end else begin
            cur_q <= cur_q + id_t'(1);
          end
        end
        ST_GNT: begin
          if (cur_q == id_t'(Clients - 1)) begin
            state_q <= ST_OUT;
          end else begin
            cur_q <= cur_q + id_t'(1);
          end
        end
        ST_OUT: begin
          // wait for the previous result to leave the output register
          if (!valid_q || out_ready) begin
            valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/prfa_dp.sv
// ----------------------------------------------------------------------------
// prfa_dp
// Queues, usage counters, resource flags and the result registers.
// ----------------------------------------------------------------------------
module prfa_dp import prfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  prfa_cmd_t              cmd_i,
  input  logic [MaskWidth-1:0]   release_mask_i,
  input  logic [MaskWidth-1:0]   request_mask_i,
  input  logic [WeightWidth-1:0] weight_i,
  output logic [MaskWidth-1:0]   grant_mask_o,
  output logic [MaskWidth-1:0]   pending_mask_o
);

  id_t    qc_q [Clients][Clients];
  usage_t qk_q [Clients][Clients];
  cnt_t   qn_q [Clients];
  usage_t usage_q [Clients];
  logic [Clients-1:0] free_q, pend_q, hold_q, req_q, gnt_q;
  logic [MaskWidth-1:0] gnt_out_q, pend_out_q;

  id_t    cur, rc;
  usage_t key;
  logic   do_ins, do_gnt;
  logic [Clients-1:0] rel_hit;

  assign cur = cmd_i.cur;
  assign rc  = right_of(cur);
  assign key = usage_q[cur];
  assign rel_hit = release_mask_i[Clients-1:0] & hold_q;
  assign do_ins = cmd_i.insert && req_q[cur] && !pend_q[cur] && !hold_q[cur];
  assign do_gnt = cmd_i.grant && qn_q[cur] != '0 && qc_q[cur][0] == cur
                  && qn_q[rc] != '0 && qc_q[rc][0] == cur && free_q[cur] && free_q[rc];

  // saturating usage add per client
  function automatic usage_t sat_add(usage_t u, logic [WeightWidth-1:0] w);
    logic [UsageWidth:0] s;
    s = {1'b0, u} + (UsageWidth+1)'(w);
    sat_add = s[UsageWidth] ? '1 : s[UsageWidth-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Clients; i++) begin
        qn_q[i]    <= '0;
        usage_q[i] <= '0;
      end
      free_q     <= '1;
      pend_q     <= '0;
      hold_q     <= '0;
      req_q      <= '0;
      gnt_q      <= '0;
      gnt_out_q  <= '0;
      pend_out_q <= '0;
    end else begin
      if (cmd_i.load) begin
        gnt_q  <= '0;
        req_q  <= request_mask_i[Clients-1:0];
        hold_q <= hold_q & ~rel_hit;
        // a release frees the client's own resource and the one to its right
        free_q <= free_q | rel_hit | {rel_hit[Clients-2:0], rel_hit[Clients-1]};
        for (int i = 0; i < Clients; i++) begin
          if (rel_hit[i]) begin
            usage_q[i] <= sat_add(usage_q[i], weight_i);
          end
        end
      end
      if (do_ins) begin
        pend_q[cur] <= 1'b1;
        // independent sorted insert into queue r: shift entries with key > new key
        for (int q = 0; q < Clients; q++) begin
          if (id_t'(q) == cur || id_t'(q) == rc) begin
            for (int k = 0; k < Clients; k++) begin
              if (cnt_t'(k) < qn_q[q]) begin
                if (qk_q[q][k] > key && k + 1 < Clients) begin
                  qc_q[q][(k + 1) % Clients] <= qc_q[q][k];
                  qk_q[q][(k + 1) % Clients] <= qk_q[q][k];
                end
                if (qk_q[q][k] > key &&
                    (k == 0 || !(qk_q[q][(k + Clients - 1) % Clients] > key))) begin
                  qc_q[q][k] <= cur;
                  qk_q[q][k] <= key;
                end
              end else if (cnt_t'(k) == qn_q[q] &&
                           (k == 0 || !(qk_q[q][(k + Clients - 1) % Clients] > key))) begin
                qc_q[q][k] <= cur;
                qk_q[q][k] <= key;
              end
            end
            qn_q[q] <= qn_q[q] + cnt_t'(1);
          end
        end
      end
      if (do_gnt) begin
        for (int q = 0; q < Clients; q++) begin
          if (id_t'(q) == cur || id_t'(q) == rc) begin
            for (int k = 0; k + 1 < Clients; k++) begin
              qc_q[q][k] <= qc_q[q][k + 1];
              qk_q[q][k] <= qk_q[q][k + 1];
            end
            qn_q[q] <= qn_q[q] - cnt_t'(1);
          end
        end
        free_q[cur] <= 1'b0;
        free_q[rc]  <= 1'b0;
        pend_q[cur] <= 1'b0;
        hold_q[cur] <= 1'b1;
        gnt_q[cur]  <= 1'b1;
      end
      if (cmd_i.publish) begin
        gnt_out_q  <= MaskWidth'(gnt_q);
        pend_out_q <= MaskWidth'(pend_q);
      end
    end
  end

  assign grant_mask_o   = gnt_out_q;
  assign pending_mask_o = pend_out_q;

endmodule

>>> src/paired_resource_fair_arbiter.sv
// ----------------------------------------------------------------------------
// paired_resource_fair_arbiter
// Ring of clients sharing paired resources, usage-fair queued grants.
// ----------------------------------------------------------------------------
// One tick enters on the in channel: release_mask_i and request_mask_i.
// Releases free a holder's two resources and add use_weight (saturating) to
// its usage; new requests are sorted into both queues of the client by
// usage; a grant pass in id order then grants clients that head both queues
// with both resources free. One result (grant_mask_o, pending_mask_o) leaves
// on the out channel per tick.
// After a tick is accepted the sequencer runs 5 insert steps, 5 grant steps
// and 1 output step, which raises out_valid, then returns to idle for the
// next tick: it takes one tick at a time, set by the single shared
// insert/grant step of the sequencer.
// The output register holds a result until taken; a stalled receiver holds
// the sequencer in its output step, and the next tick waits in front.
// The cfg channel writes use_weight (reset 100) and is always ready.
// Reset clears all queues, usage and holders, and marks every resource free.
// ----------------------------------------------------------------------------
module paired_resource_fair_arbiter import prfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [MaskWidth-1:0]   release_mask_i,
  input  logic [MaskWidth-1:0]   request_mask_i,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MaskWidth-1:0]   grant_mask_o,
  output logic [MaskWidth-1:0]   pending_mask_o,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WeightWidth-1:0] use_weight_i
);

  prfa_cmd_t cmd;
  logic [WeightWidth-1:0] weight_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightReset;
    end else if (cfg_valid) begin
      weight_q <= use_weight_i;
    end
  end

  prfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready, .cmd_o(cmd)
  );

  prfa_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .release_mask_i, .request_mask_i, .weight_i(weight_q),
    .grant_mask_o, .pending_mask_o
  );

  // a grant and a pending flag never coexist for one client
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (grant_mask_o & pending_mask_o) == '0) else $error("grant while pending");

  // no new tick taken while a result is being formed or waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready) else $error("overlapping ticks");

  // an unaccepted result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(grant_mask_o)))
    else $error("result dropped");

  // adjacent clients are never granted in one tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (grant_mask_o & {grant_mask_o[0], grant_mask_o[4:1]}) == '0)
    else $error("neighbors granted together");

endmodule
